// ===== hw/rtl/asp_pkg.sv =====
package asp_pkg;

	localparam int MAX_POINTS_DEF = 64;

	localparam int VAL_W  = 32;
	localparam int CFG_W  = 11;
	localparam int SCR_W  = 12;
	localparam int CIDX_W = 2;

	localparam logic [CFG_W-1:0] PLOT_WIDTH_RST  = CFG_W'(600);
	localparam logic [CFG_W-1:0] PLOT_HEIGHT_RST = CFG_W'(600);
	localparam logic [CFG_W-1:0] ORIGIN_X_RST    = CFG_W'(50);
	localparam logic [CFG_W-1:0] ORIGIN_Y_RST    = CFG_W'(800);

	typedef enum logic [CIDX_W-1:0] {
		REG_PLOT_WIDTH  = 2'd0,
		REG_PLOT_HEIGHT = 2'd1,
		REG_ORIGIN_X    = 2'd2,
		REG_ORIGIN_Y    = 2'd3
	} cfg_reg_t;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

endpackage

// ===== hw/rtl/asp_ram.sv =====
module asp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/autoscale_points_to_screen.sv =====
// channel | direction | handshake            | payload
// in      | in        | in_valid / in_ready  | op, x_value, y_value
// out     | out       | out_valid / out_ready| screen_x, screen_y, last, dropped
// cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Loads may arrive every cycle while in_ready is high.
// A finish walks each stored point through a store read, then per axis a
// multiply and 11 restoring divide steps on the shared divider, then an emit;
// a finish on an empty store emits nothing. in_ready is low while a finish is processed.
// No clearing pass after reset; cfg_ready is always high.
// A stalled output holds the sequencer in its emit step only.
module autoscale_points_to_screen #(
	parameter int MAX_POINTS = asp_pkg::MAX_POINTS_DEF,
	localparam int AW = $clog2(MAX_POINTS),
	localparam int CW = $clog2(MAX_POINTS + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            op,
	input  logic signed [asp_pkg::VAL_W-1:0] x_value,
	input  logic signed [asp_pkg::VAL_W-1:0] y_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [asp_pkg::SCR_W-1:0]        screen_x,
	output logic signed [asp_pkg::SCR_W-1:0] screen_y,
	output logic                            last,
	output logic                            dropped,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [asp_pkg::CIDX_W-1:0]       cfg_index,
	input  logic [asp_pkg::CFG_W-1:0]        cfg_data
);

	localparam int VW = asp_pkg::VAL_W;
	localparam int SW = asp_pkg::CFG_W;
	localparam int OW = asp_pkg::SCR_W;
	localparam int NW = VW + SW;
	localparam int KW = $clog2(SW);
	localparam logic [KW-1:0] LAST_STEP = KW'(SW - 1);

	asp_pkg::state_t state_q;

	logic [SW-1:0] plot_width_q, plot_height_q, origin_x_q, origin_y_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [AW-1:0] idx_q;
	logic          axis_q;
	logic [KW-1:0] step_q;
	logic signed [VW-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
	logic [VW-1:0] rem_q;
	logic [SW-1:0] sh_q;
	logic [SW-1:0] ox_q, oy_q;
	logic          rnz_q;

	logic          in_acc, load_acc, fin_acc, store_we;
	logic [VW-1:0] x_rd, y_rd;
	logic [VW-1:0] x_range, y_range, range_sel, diff;
	logic [SW-1:0] span_sel;
	logic [NW-1:0] prod;
	logic [VW:0]   trial;
	logic          qbit;
	logic          range_zero;
	logic          out_free;
	logic          is_last;
	logic signed [OW-1:0] base, sy;
	logic [OW-1:0] sx;

	assign in_ready  = (state_q == asp_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign load_acc  = in_acc && (op == asp_pkg::OP_LOAD);
	assign fin_acc   = in_acc && (op == asp_pkg::OP_FINISH);
	assign store_we  = load_acc && (count_q < CW'(MAX_POINTS));

	asp_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS)) u_x_ram (
		.clk   (clk),
		.we    (store_we),
		.waddr (count_q[AW-1:0]),
		.wdata (x_value),
		.raddr (idx_q),
		.rdata (x_rd)
	);

	asp_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS)) u_y_ram (
		.clk   (clk),
		.we    (store_we),
		.waddr (count_q[AW-1:0]),
		.wdata (y_value),
		.raddr (idx_q),
		.rdata (y_rd)
	);

	assign x_range    = x_max_q - x_min_q;
	assign y_range    = y_max_q - y_min_q;
	assign range_sel  = axis_q ? y_range : x_range;
	assign span_sel   = axis_q ? plot_height_q : plot_width_q;
	assign diff       = axis_q ? (y_rd - y_min_q) : (x_rd - x_min_q);
	assign prod       = NW'(diff) * NW'(span_sel);
	assign range_zero = (range_sel == '0);

	// restoring divide step: quotient bits shift in where numerator bits leave
	assign trial = {rem_q, sh_q[SW-1]};
	assign qbit  = (trial >= {1'b0, range_sel});

	assign base = $signed(OW'({1'b0, origin_y_q})) - $signed(OW'({1'b0, oy_q}));
	assign sy   = (rnz_q && (base > 0)) ? base - OW'(1) : base;
	assign sx   = OW'(origin_x_q) + OW'(ox_q);

	assign out_free = !out_valid || out_ready;
	assign is_last  = (CW'(idx_q) == count_q - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plot_width_q  <= asp_pkg::PLOT_WIDTH_RST;
			plot_height_q <= asp_pkg::PLOT_HEIGHT_RST;
			origin_x_q    <= asp_pkg::ORIGIN_X_RST;
			origin_y_q    <= asp_pkg::ORIGIN_Y_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				asp_pkg::REG_PLOT_WIDTH:  plot_width_q  <= cfg_data;
				asp_pkg::REG_PLOT_HEIGHT: plot_height_q <= cfg_data;
				asp_pkg::REG_ORIGIN_X:    origin_x_q    <= cfg_data;
				asp_pkg::REG_ORIGIN_Y:    origin_y_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			if (count_q == '0) begin
				x_min_q <= x_value;
				x_max_q <= x_value;
				y_min_q <= y_value;
				y_max_q <= y_value;
			end else begin
				if (x_value < x_min_q) x_min_q <= x_value;
				if (x_value > x_max_q) x_max_q <= x_value;
				if (y_value < y_min_q) y_min_q <= y_value;
				if (y_value > y_max_q) y_max_q <= y_value;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			asp_pkg::ST_MUL: begin
				rem_q <= prod[NW-1:SW];
				sh_q  <= prod[SW-1:0];
			end
			asp_pkg::ST_DIV: begin
				rem_q <= qbit ? VW'(trial - {1'b0, range_sel}) : trial[VW-1:0];
				sh_q  <= {sh_q[SW-2:0], qbit};
				if (step_q == LAST_STEP) begin
					if (axis_q) begin
						oy_q  <= range_zero ? '0 : {sh_q[SW-2:0], qbit};
						rnz_q <= !range_zero && (qbit ? (trial != {1'b0, range_sel})
								: (trial[VW-1:0] != '0));
					end else begin
						ox_q <= range_zero ? '0 : {sh_q[SW-2:0], qbit};
					end
				end
			end
			default: ;
		endcase
		if (state_q == asp_pkg::ST_EMIT && out_free) begin
			screen_x <= sx;
			screen_y <= sy;
			last     <= is_last;
			dropped  <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= asp_pkg::ST_IDLE;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			idx_q     <= '0;
			axis_q    <= 1'b0;
			step_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (state_q == asp_pkg::ST_EMIT && out_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				asp_pkg::ST_IDLE: begin
					if (store_we) begin
						count_q <= count_q + CW'(1);
					end else if (load_acc) begin
						ovf_q <= 1'b1;
					end else if (fin_acc) begin
						if (count_q == '0) begin
							ovf_q <= 1'b0;
						end else begin
							idx_q   <= '0;
							axis_q  <= 1'b0;
							state_q <= asp_pkg::ST_READ;
						end
					end
				end
				asp_pkg::ST_READ: begin
					state_q <= asp_pkg::ST_MUL;
				end
				asp_pkg::ST_MUL: begin
					step_q  <= '0;
					state_q <= asp_pkg::ST_DIV;
				end
				asp_pkg::ST_DIV: begin
					step_q <= step_q + KW'(1);
					if (step_q == LAST_STEP) begin
						if (axis_q) begin
							state_q <= asp_pkg::ST_EMIT;
						end else begin
							axis_q  <= 1'b1;
							state_q <= asp_pkg::ST_MUL;
						end
					end
				end
				asp_pkg::ST_EMIT: begin
					if (out_free) begin
						axis_q <= 1'b0;
						if (is_last) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= asp_pkg::ST_IDLE;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= asp_pkg::ST_READ;
						end
					end
				end
				default: state_q <= asp_pkg::ST_IDLE;
			endcase
		end
	end

endmodule

// ===== tb/tb_autoscale_points_to_screen.sv =====
`timescale 1ns / 100ps

module tb_autoscale_points_to_screen;

	localparam int VAL_W    = asp_pkg::VAL_W;
	localparam int CFG_W    = asp_pkg::CFG_W;
	localparam int SCR_W    = asp_pkg::SCR_W;
	localparam int N_PTS    = asp_pkg::MAX_POINTS_DEF;
	localparam int WD_LIMIT = 3000;
	localparam int RAND_ITEMS = 300;

	typedef struct packed {
		logic [SCR_W-1:0]        sx;
		logic signed [SCR_W-1:0] sy;
		logic                    last;
		logic                    dropped;
	} scr_pt_t;

	typedef enum {ROW_LOAD, ROW_FINISH, ROW_CONFIG} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic signed [31:0] xv;
		logic signed [31:0] yv;
		logic [CFG_W-1:0]  w, h, ox, oy;
		bit                typed;
		int                nres;
		scr_pt_t           res0;
		scr_pt_t           res1;
	} dir_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic                    op = asp_pkg::OP_LOAD;
	logic signed [VAL_W-1:0] x_value = '0;
	logic signed [VAL_W-1:0] y_value = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [SCR_W-1:0]        screen_x;
	logic signed [SCR_W-1:0] screen_y;
	logic                    last;
	logic                    dropped;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	asp_pkg::cfg_reg_t       cfg_index = asp_pkg::REG_PLOT_WIDTH;
	logic [CFG_W-1:0]        cfg_data = '0;

	autoscale_points_to_screen #(.MAX_POINTS(N_PTS)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.x_value   (x_value),
		.y_value   (y_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.screen_x  (screen_x),
		.screen_y  (screen_y),
		.last      (last),
		.dropped   (dropped),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state
	logic signed [31:0] ld_x[$];
	logic signed [31:0] ld_y[$];
	logic signed [31:0] x_lo, x_hi, y_lo, y_hi;
	bit                 overflow = 1'b0;
	logic [CFG_W-1:0]   cfg_w  = asp_pkg::PLOT_WIDTH_RST;
	logic [CFG_W-1:0]   cfg_h  = asp_pkg::PLOT_HEIGHT_RST;
	logic [CFG_W-1:0]   cfg_ox = asp_pkg::ORIGIN_X_RST;
	logic [CFG_W-1:0]   cfg_oy = asp_pkg::ORIGIN_Y_RST;

	scr_pt_t  pending_pts[$];
	dir_row_t dir_rows[$];
	scr_pt_t  mon_want, mon_got;
	int       fail_cnt = 0;
	int       idle_cyc = 0;
	int       burst_left = 0;
	logic [7:0] rdy_pat = 8'hFF;
	logic [5:0] rdy_tick = '0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic note_fail(input string msg);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("%s", msg);
	endtask

	function automatic longint axis_offset(input longint v, input longint lo,
	                                       input longint hi, input longint span,
	                                       output bit rem_nz);
		longint rng_w, num;
		rng_w = hi - lo;
		rem_nz = 1'b0;
		if (rng_w == 0)
			return 0;
		num = (v - lo) * span;
		rem_nz = (num % rng_w) != 0;
		return num / rng_w;
	endfunction

	function automatic void record_point(input logic signed [31:0] xv,
	                                     input logic signed [31:0] yv);
		if (ld_x.size() >= N_PTS) begin
			overflow = 1'b1;
		end else begin
			if (ld_x.size() == 0) begin
				x_lo = xv; x_hi = xv; y_lo = yv; y_hi = yv;
			end else begin
				if (xv < x_lo) x_lo = xv;
				if (xv > x_hi) x_hi = xv;
				if (yv < y_lo) y_lo = yv;
				if (yv > y_hi) y_hi = yv;
			end
			ld_x.push_back(xv);
			ld_y.push_back(yv);
		end
	endfunction

	function automatic void map_points(input bit keep);
		int      n;
		longint  ox, oy, base;
		bit      rx, ry;
		scr_pt_t p;
		n = ld_x.size();
		for (int i = 0; i < n; i++) begin
			ox = axis_offset(ld_x[i], x_lo, x_hi, longint'(cfg_w), rx);
			oy = axis_offset(ld_y[i], y_lo, y_hi, longint'(cfg_h), ry);
			base = longint'(cfg_oy) - oy;
			if (ry && base > 0)
				base = base - 1;
			p.sx = 12'(longint'(cfg_ox) + ox);
			p.sy = 12'(base);
			p.last = (i == n - 1);
			p.dropped = overflow;
			if (keep)
				pending_pts.push_back(p);
		end
		ld_x.delete();
		ld_y.delete();
		overflow = 1'b0;
	endfunction

	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		burst_left--;
	endtask

	task automatic push_item(input logic o, input logic signed [31:0] xv,
	                         input logic signed [31:0] yv, input bit keep);
		@(negedge clk);
		in_valid <= 1'b1;
		op <= o;
		x_value <= xv;
		y_value <= yv;
		do @(posedge clk); while (!in_ready);
		if (o == asp_pkg::OP_LOAD)
			record_point(xv, yv);
		else
			map_points(keep);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pts.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input asp_pkg::cfg_reg_t r, input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		case (r)
			asp_pkg::REG_PLOT_WIDTH:  cfg_w = v;
			asp_pkg::REG_PLOT_HEIGHT: cfg_h = v;
			asp_pkg::REG_ORIGIN_X:    cfg_ox = v;
			asp_pkg::REG_ORIGIN_Y:    cfg_oy = v;
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
	                        input logic [CFG_W-1:0] ox, input logic [CFG_W-1:0] oy);
		settle();
		write_reg(asp_pkg::REG_PLOT_WIDTH, w);
		write_reg(asp_pkg::REG_PLOT_HEIGHT, h);
		write_reg(asp_pkg::REG_ORIGIN_X, ox);
		write_reg(asp_pkg::REG_ORIGIN_Y, oy);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic void row_load(input logic signed [31:0] xv,
	                                 input logic signed [31:0] yv);
		dir_row_t r;
		r.kind = ROW_LOAD;
		r.xv = xv;
		r.yv = yv;
		r.typed = 1'b0;
		dir_rows.push_back(r);
	endfunction

	function automatic void row_finish(input bit typed, input int nres,
	                                   input scr_pt_t r0, input scr_pt_t r1);
		dir_row_t r;
		r.kind = ROW_FINISH;
		r.xv = '0;
		r.yv = '0;
		r.typed = typed;
		r.nres = nres;
		r.res0 = r0;
		r.res1 = r1;
		dir_rows.push_back(r);
	endfunction

	function automatic void row_config(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
	                                   input logic [CFG_W-1:0] ox, input logic [CFG_W-1:0] oy);
		dir_row_t r;
		r.kind = ROW_CONFIG;
		r.w = w;
		r.h = h;
		r.ox = ox;
		r.oy = oy;
		dir_rows.push_back(r);
	endfunction

	function automatic logic signed [31:0] pick_val(input int style,
	                                                input logic signed [31:0] anchor);
		case (style)
			0: return $urandom;
			1: return anchor + $urandom_range(0, 1023) - 512;
			2: return anchor;
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7FFFFFFF;
					1: return 32'sh80000000;
					2: return '0;
					default: return $urandom;
				endcase
			end
		endcase
	endfunction

	// receiver back-pressure
	always @(negedge clk) begin
		rdy_tick <= rdy_tick + 1'b1;
		if (rdy_tick == '0) begin
			if ($urandom_range(0, 3) == 0)
				rdy_pat <= 8'hFF;
			else
				rdy_pat <= 8'($urandom) | 8'h01;
		end else begin
			rdy_pat <= {rdy_pat[6:0], rdy_pat[7]};
		end
		out_ready <= rdy_pat[0];
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			mon_got = '{screen_x, screen_y, last, dropped};
			if (pending_pts.size() == 0) begin
				note_fail($sformatf("unexpected transaction: sx=%0d sy=%0d last=%0b drop=%0b",
				          mon_got.sx, mon_got.sy, mon_got.last, mon_got.dropped));
			end else begin
				mon_want = pending_pts.pop_front();
				if (mon_got.sx != mon_want.sx || mon_got.sy != mon_want.sy ||
				    mon_got.last != mon_want.last || mon_got.dropped != mon_want.dropped)
					note_fail($sformatf({"mismatch: exp sx=%0d sy=%0d last=%0b drop=%0b, ",
					                     "got sx=%0d sy=%0d last=%0b drop=%0b"},
					  mon_want.sx, mon_want.sy, mon_want.last, mon_want.dropped,
					  mon_got.sx, mon_got.sy, mon_got.last, mon_got.dropped));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cyc <= 0;
		else
			idle_cyc <= idle_cyc + 1;
		if (idle_cyc >= WD_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int         rand_sent;
		int         seq_cnt;
		int         n, sel, xs, ys;
		logic signed [31:0] ax, ay;
		scr_pt_t    none;

		rand_sent = 0;
		seq_cnt = 0;
		none = '0;

		// empty store, single point, full-scale extremes
		row_finish(1'b1, 0, none, none);
		row_load(32'sh0, 32'sh0);
		row_finish(1'b1, 1, '{12'd50, 12'sd800, 1'b1, 1'b0}, none);
		row_load(32'sh7FFFFFFF, 32'sh80000000);
		row_load(32'sh80000000, 32'sh7FFFFFFF);
		row_finish(1'b1, 2, '{12'd650, 12'sd800, 1'b0, 1'b0},
		           '{12'd50, 12'sd200, 1'b1, 1'b0});
		row_load(32'sh00010000, 32'sh00030000);
		row_load(32'sh00020000, 32'sh00010000);
		row_load(32'sh00040000, 32'sh00020000);
		row_finish(1'b0, 0, none, none);
		// x flat, y with remainder
		row_load(-32'sd5, 32'sd5);
		row_load(-32'sd5, 32'sd12);
		row_load(-32'sd5, 32'sd6);
		row_finish(1'b0, 0, none, none);
		row_config(11'd2047, 11'd2047, 11'd2047, 11'd2047);
		row_load(32'sh7FFFFFFF, 32'sh7FFFFFFF);
		row_load(32'sh80000000, 32'sh80000000);
		row_finish(1'b1, 2, '{12'd4094, 12'sd0, 1'b0, 1'b0},
		           '{12'd2047, 12'sd2047, 1'b1, 1'b0});
		// zero-size plot box
		row_config(11'd0, 11'd0, 11'd0, 11'd0);
		row_load(32'sd1, 32'sd2);
		row_load(32'sd100, 32'sd200);
		row_finish(1'b1, 2, '{12'd0, 12'sd0, 1'b0, 1'b0}, '{12'd0, 12'sd0, 1'b1, 1'b0});
		// y goes negative
		row_config(11'd1, 11'd1, 11'd0, 11'd0);
		row_load(32'sd0, 32'sd0);
		row_load(32'sd3, 32'sd3);
		row_load(32'sd1, 32'sd1);
		row_finish(1'b0, 0, none, none);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_CONFIG: set_regs(dir_rows[i].w, dir_rows[i].h,
				                     dir_rows[i].ox, dir_rows[i].oy);
				ROW_LOAD: begin
					pace();
					push_item(asp_pkg::OP_LOAD, dir_rows[i].xv, dir_rows[i].yv, 1'b1);
				end
				default: begin
					pace();
					push_item(asp_pkg::OP_FINISH, dir_rows[i].xv, dir_rows[i].yv,
					          !dir_rows[i].typed);
					if (dir_rows[i].typed && dir_rows[i].nres > 0)
						pending_pts.push_back(dir_rows[i].res0);
					if (dir_rows[i].typed && dir_rows[i].nres > 1)
						pending_pts.push_back(dir_rows[i].res1);
				end
			endcase
		end

		while (rand_sent < RAND_ITEMS) begin
			if (seq_cnt % 4 == 3) begin
				case ($urandom_range(0, 5))
					0: set_regs(11'd2047, 11'd2047, 11'd2047, 11'd2047);
					1: set_regs(11'd1, 11'd1, 11'd0, 11'd0);
					2: set_regs(11'd0, 11'($urandom), 11'($urandom), 11'($urandom));
					default: set_regs(11'($urandom), 11'($urandom),
					                  11'($urandom), 11'($urandom));
				endcase
			end
			sel = $urandom_range(0, 99);
			if (seq_cnt == 1 || sel < 8)
				n = N_PTS + $urandom_range(1, 4);
			else if (sel < 13)
				n = 0;
			else if (sel < 23)
				n = $urandom_range(20, N_PTS);
			else
				n = $urandom_range(1, 10);
			xs = $urandom_range(0, 3);
			ys = $urandom_range(0, 3);
			ax = $urandom;
			ay = $urandom;
			repeat (n) begin
				pace();
				push_item(asp_pkg::OP_LOAD, pick_val(xs, ax), pick_val(ys, ay), 1'b1);
				rand_sent++;
			end
			pace();
			push_item(asp_pkg::OP_FINISH, $urandom, $urandom, 1'b1);
			rand_sent++;
			seq_cnt++;
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pts.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
